### rtl/core/ppgw_pkg.sv
// Shared types and constants for the pixel plot display writer.
`timescale 1ns / 1ps

package ppgw_pkg;

  // Controller command bytes.
  localparam logic [7:0] CMD_EXT       = 8'h34;
  localparam logic [7:0] CMD_GFX_ON    = 8'h36;
  localparam logic [7:0] CMD_BASIC     = 8'h30;
  localparam logic [7:0] CMD_ADDR_BASE = 8'h80;
  localparam logic [7:0] CMD_COL_LOWER = 8'h88;

  // Serial frame sync bytes and nibble mask.
  localparam logic [7:0] SYNC_CMD  = 8'hF8;
  localparam logic [7:0] SYNC_DATA = 8'hFA;
  localparam logic [7:0] HI_NIBBLE = 8'hF0;

  // Width of the raw word index before it is cut to the address width.
  localparam int IDX_W = 12;

  // Which transfer the output register is loaded with.
  typedef enum logic [2:0] {
    XF_EXT = 3'd0,
    XF_ROW = 3'd1,
    XF_COL = 3'd2,
    XF_HI  = 3'd3,
    XF_LO  = 3'd4,
    XF_GON = 3'd5,
    XF_BAS = 3'd6
  } xfer_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;
    logic  word_wr;
    logic  clear_step;
    logic  load_out;
    xfer_t out_sel;
    logic  out_last;
  } ppgw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;
    logic clear_done;
  } ppgw_stat_t;

endpackage

### rtl/core/ppgw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ppgw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/ppgw_ctrl.sv
// Controller state machine that sequences the clearing pass and the transfers of a request.
`timescale 1ns / 1ps

module ppgw_ctrl
  import ppgw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  ppgw_stat_t stat,
  output ppgw_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ROW   = 8'b0000_0100,
    S_COL   = 8'b0000_1000,
    S_HI    = 8'b0001_0000,
    S_LO    = 8'b0010_0000,
    S_GON   = 8'b0100_0000,
    S_BAS   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new word if it is empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign out_valid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.out_sel = XF_EXT;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && out_free) begin
          cmd.capture  = 1'b1;
          cmd.load_out = 1'b1;
          cmd.out_sel  = XF_EXT;
          cmd.out_last = !stat.in_range;
          state_nxt    = stat.in_range ? S_ROW : S_IDLE;
        end
      end
      S_ROW: begin
        // Read data is stable here, so the updated word is written back.
        cmd.word_wr = 1'b1;
        cmd.out_sel = XF_ROW;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_COL;
        end
      end
      S_COL: begin
        cmd.out_sel = XF_COL;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_HI;
        end
      end
      S_HI: begin
        cmd.out_sel = XF_HI;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_LO;
        end
      end
      S_LO: begin
        cmd.out_sel = XF_LO;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_GON;
        end
      end
      S_GON: begin
        cmd.out_sel = XF_GON;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_BAS;
        end
      end
      S_BAS: begin
        cmd.out_sel  = XF_BAS;
        cmd.out_last = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Output valid flag follows loads and drains.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/ppgw_dpath.sv
// Datapath: shadow frame store, pixel update and transfer word formatting.
`timescale 1ns / 1ps

module ppgw_dpath
  import ppgw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_pix_x,
  input  logic [7:0]  in_pix_y,
  input  logic        in_colour,
  input  ppgw_cmd_t   cmd,
  output ppgw_stat_t  stat,
  output logic        out_is_data,
  output logic [7:0]  out_value,
  output logic [23:0] out_frame,
  output logic        out_last
);

  localparam int WPR   = (SCREEN_WIDTH + 15) / 16;
  localparam int DEPTH = WPR * SCREEN_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HALF  = SCREEN_HEIGHT / 2;

  logic [7:0]    x_r;
  logic [7:0]    y_r;
  logic          colour_r;
  logic [AW-1:0] idx_r;
  logic [15:0]   word_r;
  logic [AW-1:0] clr_addr_r;

  logic [IDX_W-1:0] idx_full;
  logic [15:0]      rdata;
  logic [15:0]      pix_mask;
  logic [15:0]      new_word;
  logic             lower;
  logic [7:0]       row_off;
  logic [7:0]       row_cmd;
  logic [7:0]       col_cmd;
  logic [7:0]       val;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [15:0]      ram_wdata;

  // Range check and word index of the incoming request.
  assign stat.in_range = ({1'b0, in_pix_x} < 9'(SCREEN_WIDTH)) &&
                         ({1'b0, in_pix_y} < 9'(SCREEN_HEIGHT));
  assign idx_full = {4'b0, in_pix_y} * IDX_W'(WPR) + IDX_W'(in_pix_x[7:4]);
  assign stat.clear_done = (clr_addr_r == AW'(DEPTH - 1));

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r      <= in_pix_x;
      y_r      <= in_pix_y;
      colour_r <= in_colour;
      idx_r    <= idx_full[AW-1:0];
    end
  end

  // Clearing pass address counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_step && !stat.clear_done) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Read-modify-write of the word that holds the pixel.
  assign pix_mask = 16'h8000 >> x_r[3:0];
  assign new_word = colour_r ? (rdata | pix_mask) : (rdata & ~pix_mask);

  always_ff @(posedge clk) begin
    if (cmd.word_wr) begin
      word_r <= new_word;
    end
  end

  assign ram_we    = cmd.clear_step || cmd.word_wr;
  assign ram_waddr = cmd.clear_step ? clr_addr_r : idx_r;
  assign ram_wdata = cmd.clear_step ? 16'h0000 : new_word;

  ppgw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture && stat.in_range),
    .raddr (idx_full[AW-1:0]),
    .rdata (rdata)
  );

  // Address commands; the lower half uses a row offset and the second column base.
  assign lower   = (y_r >= 8'(HALF));
  assign row_off = lower ? (y_r - 8'(HALF)) : y_r;
  assign row_cmd = CMD_ADDR_BASE + row_off;
  assign col_cmd = (lower ? CMD_COL_LOWER : CMD_ADDR_BASE) + {4'b0, x_r[7:4]};

  // Byte selection for the next transfer.
  always_comb begin
    case (cmd.out_sel)
      XF_EXT:  val = CMD_EXT;
      XF_ROW:  val = row_cmd;
      XF_COL:  val = col_cmd;
      XF_HI:   val = word_r[15:8];
      XF_LO:   val = word_r[7:0];
      XF_GON:  val = CMD_GFX_ON;
      XF_BAS:  val = CMD_BASIC;
      default: val = CMD_EXT;
    endcase
  end

  // Output word register with its serial frame.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_is_data <= (cmd.out_sel == XF_HI) || (cmd.out_sel == XF_LO);
      out_value   <= val;
      out_frame   <= {((cmd.out_sel == XF_HI) || (cmd.out_sel == XF_LO)) ? SYNC_DATA
                                                                          : SYNC_CMD,
                      val & HI_NIBBLE, val[3:0], 4'b0000};
      out_last    <= cmd.out_last;
    end
  end

endmodule

### rtl/core/pixel_plot_gdram_writer.sv
// Top level of the pixel plot writer: controller, datapath and shadow frame store.
// Usage:
//   The in_ channel takes one pixel request word (x, y, colour). Colour 1 sets the
//   pixel, 0 clears it; the shadow store keeps one 16-bit word per 16 pixels.
//   The out_ channel gives one controller transfer word per handshake: is_data,
//   the byte, its 24-bit serial frame, and last on the final word of a request.
//   An in-range request gives seven words: 0x34, row, column, high byte, low
//   byte, 0x36, 0x30. An out-of-range request gives 0x34 alone with last set.
//   The first word appears in the cycle after acceptance and, while out_stall
//   is low, one word follows per cycle.
//   A request is taken once the previous one has loaded its last word and the
//   output register is free, so the next request overlaps the last word waiting.
//   After reset a clearing pass zeroes the store, one word per cycle over all
//   ceil(SCREEN_WIDTH/16) * SCREEN_HEIGHT words (512 at the defaults); in_stall
//   stays high meanwhile. When out_stall is high a valid output word holds and
//   the sequence pauses.
`timescale 1ns / 1ps

module pixel_plot_gdram_writer
  import ppgw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pix_x,
  input  logic [7:0]  in_pix_y,
  input  logic        in_colour,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_data,
  output logic [7:0]  out_value,
  output logic [23:0] out_frame,
  output logic        out_last
);

  ppgw_cmd_t  cmd;
  ppgw_stat_t stat;

  // Sequencer.
  ppgw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store, update and formatting.
  ppgw_dpath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix_x    (in_pix_x),
    .in_pix_y    (in_pix_y),
    .in_colour   (in_colour),
    .cmd         (cmd),
    .stat        (stat),
    .out_is_data (out_is_data),
    .out_value   (out_value),
    .out_frame   (out_frame),
    .out_last    (out_last)
  );

endmodule
